// File: rtl/ps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Prime sieve package
// Shared widths, microcode encoding and the microcode program of the sieve.
// ----------------------------------------------------------------------------
package ps_pkg;

    localparam int LIMIT_W = 13;
    localparam int INDEX_W = 6;
    localparam int MASK_W  = 64;
    localparam int DEPTH   = 64;
    localparam int ROOT_W  = 7;
    localparam int PC_W    = 4;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_INIT,
        OP_ISETUP,
        OP_RDI,
        OP_JSETUP,
        OP_RDJ,
        OP_CLRJ,
        OP_INEXT,
        OP_ESETUP,
        OP_RDW,
        OP_OUT,
        OP_WNEXT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_MORE_WORDS,
        C_NO_MORE_WORDS,
        C_SQ_GE_LIM,
        C_NOT_PRIME,
        C_J_GE_LIM,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ucode_t;

    typedef struct packed {
        logic accept;
        logic more_words;
        logic out_busy;
        logic sq_ge_lim;
        logic not_prime;
        logic j_ge_lim;
    } cond_flags_t;

    localparam pc_t ST_IDLE  = 4'd0;
    localparam pc_t ST_INIT  = 4'd1;
    localparam pc_t ST_ISET  = 4'd2;
    localparam pc_t ST_ITEST = 4'd3;
    localparam pc_t ST_ICHK  = 4'd4;
    localparam pc_t ST_JTEST = 4'd5;
    localparam pc_t ST_JCLR  = 4'd6;
    localparam pc_t ST_INEXT = 4'd7;
    localparam pc_t ST_ESET  = 4'd8;
    localparam pc_t ST_ERD   = 4'd9;
    localparam pc_t ST_EOUT  = 4'd10;
    localparam pc_t ST_ENEXT = 4'd11;
    localparam pc_t ST_ELOOP = 4'd12;

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t uc;
        uc.op     = OP_NOP;
        uc.cond   = C_ALWAYS;
        uc.target = ST_IDLE;
        case (pc)
            ST_IDLE: begin
                uc.op = OP_ACCEPT;   uc.cond = C_NO_ACCEPT;     uc.target = ST_IDLE;
            end
            ST_INIT: begin
                uc.op = OP_INIT;     uc.cond = C_MORE_WORDS;    uc.target = ST_INIT;
            end
            ST_ISET: begin
                uc.op = OP_ISETUP;   uc.cond = C_NEVER;         uc.target = ST_IDLE;
            end
            ST_ITEST: begin
                uc.op = OP_RDI;      uc.cond = C_SQ_GE_LIM;     uc.target = ST_ESET;
            end
            ST_ICHK: begin
                uc.op = OP_JSETUP;   uc.cond = C_NOT_PRIME;     uc.target = ST_INEXT;
            end
            ST_JTEST: begin
                uc.op = OP_RDJ;      uc.cond = C_J_GE_LIM;      uc.target = ST_INEXT;
            end
            ST_JCLR: begin
                uc.op = OP_CLRJ;     uc.cond = C_ALWAYS;        uc.target = ST_JTEST;
            end
            ST_INEXT: begin
                uc.op = OP_INEXT;    uc.cond = C_ALWAYS;        uc.target = ST_ITEST;
            end
            ST_ESET: begin
                uc.op = OP_ESETUP;   uc.cond = C_NEVER;         uc.target = ST_IDLE;
            end
            ST_ERD: begin
                uc.op = OP_RDW;      uc.cond = C_NEVER;         uc.target = ST_IDLE;
            end
            ST_EOUT: begin
                uc.op = OP_OUT;      uc.cond = C_OUT_BUSY;      uc.target = ST_EOUT;
            end
            ST_ENEXT: begin
                uc.op = OP_WNEXT;    uc.cond = C_NO_MORE_WORDS; uc.target = ST_IDLE;
            end
            ST_ELOOP: begin
                uc.op = OP_NOP;      uc.cond = C_ALWAYS;        uc.target = ST_ERD;
            end
            default: begin
                uc.op = OP_NOP;      uc.cond = C_ALWAYS;        uc.target = ST_IDLE;
            end
        endcase
        return uc;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ps_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Prime sieve sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module ps_seq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ps_pkg::cond_flags_t flags,
    output ps_pkg::ucode_t           uc
);
    import ps_pkg::*;

    pc_t  pc_reg;
    pc_t  pc_next;
    logic take;

    assign uc = ucode_rom(pc_reg);

    always_comb begin
        case (uc.cond)
            C_NEVER:         take = 1'b0;
            C_ALWAYS:        take = 1'b1;
            C_NO_ACCEPT:     take = !flags.accept;
            C_MORE_WORDS:    take = flags.more_words;
            C_NO_MORE_WORDS: take = !flags.more_words;
            C_SQ_GE_LIM:     take = flags.sq_ge_lim;
            C_NOT_PRIME:     take = flags.not_prime;
            C_J_GE_LIM:      take = flags.j_ge_lim;
            C_OUT_BUSY:      take = flags.out_busy;
            default:         take = 1'b1;
        endcase
        pc_next = take ? uc.target : pc_reg + pc_t'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ST_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/prime_sieve_unit.sv
// Sequence: each request fills the mask words, tests each candidate below the square
// root of the limit, clears the multiples of each prime, then reads and outputs each
// mask word, waiting while the output stalls.
// Throughput: one request at a time; the flag memory read-modify-write sets the pace.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// The flag memory is not cleared; each request rewrites every word it reads.
`default_nettype none
// ----------------------------------------------------------------------------
// Prime sieve unit
// Sieve of Eratosthenes over a flag memory, driven by a microcoded sequencer,
// emitting the primes below each limit as mask words.
// ----------------------------------------------------------------------------
module prime_sieve_unit #(
    parameter int MAX_LIMIT = 4096,
    parameter int WORD_BITS = 64
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [ps_pkg::LIMIT_W-1:0]  s_limit,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [ps_pkg::INDEX_W-1:0]       m_word_index,
    output logic [ps_pkg::MASK_W-1:0]        m_prime_mask,
    output logic                             m_last
);
    import ps_pkg::*;

    localparam int CAP       = DEPTH * WORD_BITS;
    localparam int EFF_LIMIT = (MAX_LIMIT < CAP) ? MAX_LIMIT : CAP;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam logic [LIMIT_W-1:0]   EFF_LIM_C = LIMIT_W'(EFF_LIMIT);
    localparam logic [LIMIT_W-1:0]   WB_L      = LIMIT_W'(WORD_BITS);
    localparam logic [BIT_W:0]       WB_B      = (BIT_W+1)'(WORD_BITS);
    localparam logic [WORD_BITS-1:0] ONES      = '1;

    ucode_t      uc;
    cond_flags_t flags;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    logic [LIMIT_W-1:0] lim_reg;
    logic [LIMIT_W-1:0] base_reg;
    logic [INDEX_W-1:0] w_reg;
    logic [ROOT_W-1:0]  i_reg;
    logic [INDEX_W-1:0] iw_reg;
    logic [BIT_W-1:0]   ib_reg;
    logic [LIMIT_W-1:0] sq_reg;
    logic [INDEX_W-1:0] sqw_reg;
    logic [BIT_W-1:0]   sqb_reg;
    logic [LIMIT_W-1:0] j_reg;
    logic [INDEX_W-1:0] jw_reg;
    logic [BIT_W-1:0]   jb_reg;

    logic               m_valid_reg;
    logic [INDEX_W-1:0] m_word_index_reg;
    logic [MASK_W-1:0]  m_prime_mask_reg;
    logic               m_last_reg;

    logic [LIMIT_W-1:0]   sat_limit;
    logic [LIMIT_W-1:0]   rem;
    logic [WORD_BITS-1:0] init_mask;
    logic [INDEX_W-1:0]   rd_addr;
    logic [INDEX_W-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 wr_en;
    logic                 accept;
    logic                 out_busy;
    logic                 more_words;

    logic [INDEX_W-1:0] t1w, t2w, sqw_next, iw_next, jw_next;
    logic [BIT_W-1:0]   t1b, t2b, sqb_next, ib_next, jb_next;

    // Adds two numbers held as word index and bit offset.
    function automatic logic [INDEX_W+BIT_W-1:0] wb_add(
        input logic [INDEX_W-1:0] w,
        input logic [BIT_W-1:0]   b,
        input logic [INDEX_W-1:0] aw,
        input logic [BIT_W-1:0]   ab
    );
        logic [BIT_W:0]     s;
        logic [BIT_W:0]     bo;
        logic [INDEX_W-1:0] wo;
        s = {1'b0, b} + {1'b0, ab};
        if (s >= WB_B) begin
            bo = s - WB_B;
            wo = w + aw + INDEX_W'(1);
        end else begin
            bo = s;
            wo = w + aw;
        end
        return {wo, bo[BIT_W-1:0]};
    endfunction

    ps_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .uc      (uc)
    );

    assign s_ready    = aresetn && (uc.op == OP_ACCEPT);
    assign accept     = s_valid && s_ready;
    assign out_busy   = m_valid_reg && !m_ready;
    assign more_words = (base_reg + WB_L) < lim_reg;

    always_comb begin
        flags.accept     = accept;
        flags.more_words = more_words;
        flags.out_busy   = out_busy;
        flags.sq_ge_lim  = sq_reg >= lim_reg;
        flags.not_prime  = !rdata_reg[ib_reg];
        flags.j_ge_lim   = j_reg >= lim_reg;
    end

    always_comb begin
        sat_limit = (s_limit > EFF_LIM_C) ? EFF_LIM_C : s_limit;
        rem       = lim_reg - base_reg;
        if (rem >= WB_L) begin
            init_mask = ONES;
        end else begin
            init_mask = ONES >> (WB_L - rem);
        end
        if (base_reg == '0) begin
            init_mask[1:0] = 2'b00;
        end
    end

    always_comb begin
        {t1w, t1b}           = wb_add(sqw_reg, sqb_reg, iw_reg, ib_reg);
        {t2w, t2b}           = wb_add(t1w, t1b, iw_reg, ib_reg);
        {sqw_next, sqb_next} = wb_add(t2w, t2b, '0, BIT_W'(1));
        {iw_next, ib_next}   = wb_add(iw_reg, ib_reg, '0, BIT_W'(1));
        {jw_next, jb_next}   = wb_add(jw_reg, jb_reg, iw_reg, ib_reg);
    end

    always_comb begin
        case (uc.op)
            OP_RDI:  rd_addr = iw_reg;
            OP_RDJ:  rd_addr = jw_reg;
            default: rd_addr = w_reg;
        endcase
        wr_en   = (uc.op == OP_INIT) || (uc.op == OP_CLRJ);
        wr_addr = (uc.op == OP_CLRJ) ? jw_reg : w_reg;
        wr_data = (uc.op == OP_CLRJ) ? (rdata_reg & ~(WORD_BITS'(1) << jb_reg)) : init_mask;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        case (uc.op)
            OP_ACCEPT: begin
                if (accept) begin
                    lim_reg  <= sat_limit;
                    base_reg <= '0;
                    w_reg    <= '0;
                end
            end
            OP_INIT, OP_WNEXT: begin
                base_reg <= base_reg + WB_L;
                w_reg    <= w_reg + INDEX_W'(1);
            end
            OP_ISETUP: begin
                i_reg   <= ROOT_W'(2);
                iw_reg  <= '0;
                ib_reg  <= BIT_W'(2);
                sq_reg  <= LIMIT_W'(4);
                sqw_reg <= '0;
                sqb_reg <= BIT_W'(4);
            end
            OP_JSETUP: begin
                j_reg  <= sq_reg;
                jw_reg <= sqw_reg;
                jb_reg <= sqb_reg;
            end
            OP_CLRJ: begin
                j_reg  <= j_reg + LIMIT_W'(i_reg);
                jw_reg <= jw_next;
                jb_reg <= jb_next;
            end
            OP_INEXT: begin
                sq_reg  <= sq_reg + LIMIT_W'({i_reg, 1'b1});
                sqw_reg <= sqw_next;
                sqb_reg <= sqb_next;
                i_reg   <= i_reg + ROOT_W'(1);
                iw_reg  <= iw_next;
                ib_reg  <= ib_next;
            end
            OP_ESETUP: begin
                base_reg <= '0;
                w_reg    <= '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((uc.op == OP_OUT) && !out_busy) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((uc.op == OP_OUT) && !out_busy) begin
            m_word_index_reg <= w_reg;
            m_prime_mask_reg <= MASK_W'(rdata_reg);
            m_last_reg       <= !more_words;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_word_index = m_word_index_reg;
    assign m_prime_mask = m_prime_mask_reg;
    assign m_last       = m_last_reg;

endmodule
`default_nettype wire

// File: rtl/ps_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Prime sieve port checker
// Watches the ports of the sieve unit for handshake, ordering and zero/one flag errors.
// ----------------------------------------------------------------------------
module ps_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [ps_pkg::INDEX_W-1:0]  m_word_index,
    input wire logic [ps_pkg::MASK_W-1:0]   m_prime_mask,
    input wire logic                        m_last
);
    import ps_pkg::*;

    logic [INDEX_W-1:0] exp_index_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_index_reg <= '0;
        end else if (m_valid && m_ready) begin
            exp_index_reg <= m_last ? '0 : exp_index_reg + INDEX_W'(1);
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prime_mask)
            && $stable(m_word_index) && $stable(m_last))
        else $error("result changed while stalled");

    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word_index == exp_index_reg)
        else $error("mask words out of order");

    a_ready_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    a_zero_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_word_index == '0) |-> m_prime_mask[1:0] == 2'b00)
        else $error("zero or one flagged as prime");

endmodule

bind prime_sieve_unit ps_checker u_ps_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_word_index (m_word_index),
    .m_prime_mask (m_prime_mask),
    .m_last       (m_last)
);
`default_nettype wire
